FILE: hw/rtl/psg_pkg.sv
// Shared types, constants and helper functions of the square and noise sound generator.
`default_nettype none
package psg_pkg;

  // Configuration register widths and indexes
  localparam int TICK_W    = 20;
  localparam int SRATE_W   = 18;
  localparam int GAIN_W    = 12;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd2;

  localparam logic [TICK_W-1:0]  TICK_RATE_RST  = 20'd223721;
  localparam logic [SRATE_W-1:0] AUDIO_RATE_RST = 18'd44100;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 12'd256;

  // Datapath widths
  localparam int TONE_W   = 10;
  localparam int PERIOD_W = 12;
  localparam int ACC_W    = 21;
  localparam int VOL_W    = 4;
  localparam int ENTRY_W  = 13;
  localparam int LEVEL_W  = 15;
  localparam int SAMPLE_W = 19;
  localparam int OUT_TDATA_W = 24;
  localparam int NCHAN    = 4;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 12'h400;
  localparam logic [VOL_W-1:0]    VOL_SILENT = 4'd15;

  // Chip register indexes (tone periods and noise control; the rest are volumes)
  localparam logic [2:0] REG_TONE0 = 3'd0;
  localparam logic [2:0] REG_TONE1 = 3'd2;
  localparam logic [2:0] REG_TONE2 = 3'd4;
  localparam logic [2:0] REG_NOISE = 3'd6;

  localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       latch;
    logic [2:0] idx;
    logic [7:0] data;
  } cmd_t;

  // Truncated 2 dB per step attenuation table, last entry silent
  function automatic logic [ENTRY_W-1:0] level_of(input logic [VOL_W-1:0] v);
    logic [ENTRY_W-1:0] r;
    case (v)
      4'd0:    r = 13'd8191;
      4'd1:    r = 13'd6506;
      4'd2:    r = 13'd5168;
      4'd3:    r = 13'd4105;
      4'd4:    r = 13'd3260;
      4'd5:    r = 13'd2590;
      4'd6:    r = 13'd2057;
      4'd7:    r = 13'd1634;
      4'd8:    r = 13'd1298;
      4'd9:    r = 13'd1031;
      4'd10:   r = 13'd819;
      4'd11:   r = 13'd650;
      4'd12:   r = 13'd516;
      4'd13:   r = 13'd410;
      4'd14:   r = 13'd326;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  // Noise shift period from the rate bits; rate three follows tone 2 doubled
  function automatic logic [PERIOD_W-1:0] noise_period(input logic [1:0] rate,
                                                       input logic [PERIOD_W-1:0] tone2);
    logic [PERIOD_W-1:0] r;
    case (rate)
      2'd0:    r = 12'd32;
      2'd1:    r = 12'd64;
      2'd2:    r = 12'd128;
      default: r = {tone2[PERIOD_W-2:0], 1'b0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/psg_front.sv
// Front end: accept input items, resolve the target register and queue commands.
`default_nettype none
module psg_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output      logic          s_tready,
  input  wire logic [7:0]    s_tdata,
  input  wire logic          s_tuser,
  input  wire logic          q_full,
  output      logic          q_push,
  output      psg_pkg::cmd_t q_cmd
);
  import psg_pkg::*;

  logic [2:0] latched_index;
  logic       take;

  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;
  assign q_push   = take;

  // Latch bytes carry their own index; data bytes go to the last latched one
  always_comb begin
    q_cmd.kind  = s_tuser ? CMD_SAMPLE : CMD_WRITE;
    q_cmd.latch = s_tdata[7];
    q_cmd.idx   = s_tdata[7] ? s_tdata[6:4] : latched_index;
    q_cmd.data  = s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_index <= 3'd0;
    end else if (take && !s_tuser && s_tdata[7]) begin
      latched_index <= s_tdata[6:4];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/psg_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none
module psg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire psg_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output      psg_pkg::cmd_t head,
  output      logic          full,
  output      logic          empty
);
  import psg_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/psg_back.sv
// Back end: run register writes, chip ticks, level mix and gain scaling.
`default_nettype none
module psg_back #(
  parameter int NOISE_BITS = 17
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [psg_pkg::TICK_W-1:0]  tick_rate,
  input  wire logic [psg_pkg::SRATE_W-1:0] audio_rate,
  input  wire logic [psg_pkg::GAIN_W-1:0]  gain,
  input  wire psg_pkg::cmd_t               cmd,
  input  wire logic                        q_empty,
  output      logic                        pop,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [psg_pkg::SAMPLE_W-1:0] sample_value
);
  import psg_pkg::*;

  localparam logic [NOISE_BITS-1:0] NOISE_TOP = {1'b1, {(NOISE_BITS-1){1'b0}}};
  localparam int PROD_W = LEVEL_W + GAIN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SUM,
    ST_EMIT
  } state_t;

  state_t                state;
  logic [TONE_W-1:0]     tone_reg   [3];
  logic [2:0]            noise_ctl;
  logic [PERIOD_W-1:0]   periods    [NCHAN];
  logic [PERIOD_W-1:0]   countdowns [NCHAN];
  logic [NCHAN-1:0]      levels;
  logic [VOL_W-1:0]      vol        [NCHAN];
  logic [NOISE_BITS-1:0] noise_shift;
  logic [ACC_W-1:0]      acc;
  logic [LEVEL_W-1:0]    level_sum;

  logic [SRATE_W-1:0]    modulus;
  logic [ACC_W-1:0]      modulus_ext;
  logic                  tick_due;
  logic [PERIOD_W-1:0]   cd_next    [NCHAN];
  logic [NCHAN-1:0]      levels_next;
  logic [NOISE_BITS-1:0] noise_next;
  logic [LEVEL_W-1:0]    level_sum_next;
  logic [PROD_W-1:0]     product;

  logic [1:0]            ch;
  logic                  is_tone;
  logic                  is_noise;
  logic [TONE_W-1:0]     tone_cur;
  logic [TONE_W-1:0]     tone_val;
  logic [PERIOD_W-1:0]   tone_per;

  assign pop         = (state == ST_IDLE) && !q_empty;
  assign modulus     = (audio_rate == '0) ? SRATE_W'(1) : audio_rate;
  assign modulus_ext = ACC_W'(modulus);
  assign tick_due    = (acc >= modulus_ext);
  assign product     = PROD_W'(level_sum) * PROD_W'(gain);

  // One chip tick: tone countdowns, and the noise shifter on its own reload
  always_comb begin
    logic reload;
    logic fb;
    for (int i = 0; i < NCHAN; i++) begin
      reload     = (countdowns[i] <= PERIOD_W'(1));
      cd_next[i] = reload ? periods[i] : countdowns[i] - 1'b1;
      levels_next[i] = levels[i] ^ reload;
    end
    fb = noise_shift[2] ^ (noise_shift[3] & noise_ctl[2]);
    if (countdowns[NCHAN-1] <= PERIOD_W'(1)) begin
      noise_next           = {fb, noise_shift[NOISE_BITS-1:1]};
      levels_next[NCHAN-1] = noise_shift[1];
    end else begin
      noise_next           = noise_shift;
      levels_next[NCHAN-1] = levels[NCHAN-1];
    end
  end

  // Sum volumes of the channels whose output is high
  always_comb begin
    level_sum_next = '0;
    for (int i = 0; i < NCHAN; i++) begin
      if (levels[i]) begin
        level_sum_next = level_sum_next + LEVEL_W'(level_of(vol[i]));
      end
    end
  end

  // Decode a register write
  always_comb begin
    ch       = cmd.idx[2:1];
    is_tone  = (cmd.idx inside {REG_TONE0, REG_TONE1, REG_TONE2});
    is_noise = (cmd.idx == REG_NOISE);
    case (ch)
      2'd0:    tone_cur = tone_reg[0];
      2'd1:    tone_cur = tone_reg[1];
      default: tone_cur = tone_reg[2];
    endcase
    tone_val = cmd.latch ? {tone_cur[TONE_W-1:4], cmd.data[3:0]}
                         : {cmd.data[5:0], tone_cur[3:0]};
    tone_per = (tone_val != '0) ? PERIOD_W'(tone_val) : PERIOD_RST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      noise_ctl    <= 3'd0;
      levels       <= '0;
      noise_shift  <= NOISE_TOP;
      acc          <= '0;
      for (int i = 0; i < 3; i++) begin
        tone_reg[i] <= '0;
      end
      for (int i = 0; i < NCHAN; i++) begin
        periods[i]    <= PERIOD_RST;
        countdowns[i] <= PERIOD_RST;
        vol[i]        <= VOL_SILENT;
      end
    end else begin
      // Drop the sample once taken, unless a new one replaces it this cycle
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (cmd.kind == CMD_SAMPLE) begin
              acc   <= acc + ACC_W'(tick_rate);
              state <= ST_TICK;
            end else if (is_tone) begin
              tone_reg[ch] <= tone_val;
              periods[ch]  <= tone_per;
              if (ch == 2'd2 && noise_ctl[1:0] == NOISE_RATE_TONE2) begin
                periods[NCHAN-1] <= {tone_per[PERIOD_W-2:0], 1'b0};
              end
            end else if (is_noise) begin
              noise_ctl        <= cmd.data[2:0];
              periods[NCHAN-1] <= noise_period(cmd.data[1:0], periods[2]);
              noise_shift      <= NOISE_TOP;
            end else begin
              vol[ch] <= cmd.data[3:0];
            end
          end
        end
        ST_TICK: begin
          // One tick per whole sample period held in the accumulator
          if (tick_due) begin
            acc         <= acc - modulus_ext;
            countdowns  <= cd_next;
            levels      <= levels_next;
            noise_shift <= noise_next;
          end else begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          level_sum <= level_sum_next;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            sample_value <= product[PROD_W-1:8];
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/square_noise_sound_generator.sv
// Top level: three tone channels and one noise channel, item stream in, sample stream out.
// A write item takes effect in the back-end registers as it is popped from the queue.
// A sample item steps through the back end: start, one step per chip tick it runs, leave
// the tick loop, mix, then scale and register the sample, waiting while the output is held.
// Items are queued two deep ahead of the back end; one item executes at a time.
// Reset (rst, synchronous): all channel state, config registers and the command queue
// return to power-on values.
`default_nettype none
module square_noise_sound_generator #(
  parameter int NOISE_BITS = 17
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input item stream
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  wire logic                           s_tuser,   // [0] action: 0 write, 1 sample
  // Sample output stream
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [psg_pkg::OUT_TDATA_W-1:0] m_tdata,  // [18:0] sample_value, rest zero
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [psg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [psg_pkg::CFG_W-1:0]      cfg_data
);
  import psg_pkg::*;

  logic [TICK_W-1:0]   tick_rate;
  logic [SRATE_W-1:0]  audio_rate;
  logic [GAIN_W-1:0]   gain;

  cmd_t                push_cmd;
  cmd_t                head_cmd;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  logic [SAMPLE_W-1:0] sample_value;

  // Config registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate  <= TICK_RATE_RST;
      audio_rate <= AUDIO_RATE_RST;
      gain       <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_RATE:  tick_rate  <= cfg_data[TICK_W-1:0];
        CFG_AUDIO_RATE: audio_rate <= cfg_data[SRATE_W-1:0];
        CFG_GAIN:       gain       <= cfg_data[GAIN_W-1:0];
        default:        ;
      endcase
    end
  end

  // Front end: accept and resolve the target register of each command byte
  psg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  // Hold commands so the front keeps accepting while the back ticks
  psg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: execute writes, advance the chip and produce samples
  psg_back #(
    .NOISE_BITS (NOISE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tick_rate    (tick_rate),
    .audio_rate   (audio_rate),
    .gain         (gain),
    .cmd          (head_cmd),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .sample_value (sample_value)
  );

  // Pad the sample up to whole bytes
  assign m_tdata = {{(OUT_TDATA_W-SAMPLE_W){1'b0}}, sample_value};

endmodule
`default_nettype wire

FILE: dv/square_noise_sound_generator_test.sv
// Self-checking testbench for the square and noise sound generator stream block.
`timescale 1ns / 1ps
module square_noise_sound_generator_test;
  import psg_pkg::*;

  localparam int LFSR_W = 17;
  localparam logic [LFSR_W-1:0] LFSR_TOP = LFSR_W'(1) << (LFSR_W - 1);
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_IDX = 2'd3;

  // Cycles to let queued write items retire before a register write; a write item
  // never produces a sample, so the drained result queue alone does not prove idle.
  localparam int SETTLE_CYCLES = 20;
  // Tail after the last expected sample: a few ticks plus the mix and scale.
  localparam int END_CYCLES = 100;
  // Slowest correct run is about 1.1 ms; allow several times that.
  localparam int RUN_LIMIT_NS = 8_000_000;
  // Pressure points: receiver long hold and sender drain pause.
  localparam int HOLD_AT_SAMPLE = 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_AT_ITEM = 900;

  typedef struct {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
  } psg_item_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;  // [7:0] data_byte
  logic s_tuser = 1'b0;        // [0] action: 0 write, 1 sample
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;  // [18:0] sample_value, rest zero
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  square_noise_sound_generator #(.NOISE_BITS(LFSR_W)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sound chip predictor: its own copy of the registers, channels and rate
  // accumulator, advanced once per accepted item.
  // ---------------------------------------------------------------------------
  logic [TONE_W-1:0]   reg_val [8];
  logic [2:0]          sel_reg;
  logic [PERIOD_W-1:0] chan_period [NCHAN];
  logic [PERIOD_W-1:0] chan_count [NCHAN];
  logic                chan_level [NCHAN];
  logic [VOL_W-1:0]    chan_atten [NCHAN];
  logic [LFSR_W-1:0]   lfsr;
  logic [ACC_W-1:0]    phase_acc;
  logic [TICK_W-1:0]   cfg_tick;
  logic [SRATE_W-1:0]  cfg_srate;
  logic [GAIN_W-1:0]   cfg_gain;

  // 2 dB per step, 8191 * 10^(-i/10) truncated; the last step is silence.
  int unsigned atten_level [16] = '{8191, 6506, 5168, 4105, 3260, 2590, 2057, 1634,
                                    1298, 1031, 819, 650, 516, 410, 326, 0};

  logic [SAMPLE_W-1:0] sample_expect_q [$];
  psg_item_t cmd_backlog [$];

  int unsigned mismatch_count = 0;
  int unsigned items_accepted = 0;
  int unsigned samples_seen = 0;
  int unsigned send_gap = 0;
  int unsigned ready_gap = 0;
  int unsigned long_hold = 0;
  bit drain_pause = 1'b0;
  bit no_idle = 1'b0;

  task automatic psg_reset_model();
    int c;
    cfg_tick = TICK_RATE_RST;
    cfg_srate = AUDIO_RATE_RST;
    cfg_gain = GAIN_RST;
    for (c = 0; c < 8; c++) reg_val[c] = '0;
    sel_reg = '0;
    for (c = 0; c < NCHAN; c++) begin
      chan_period[c] = PERIOD_RST;
      chan_count[c] = PERIOD_RST;
      chan_level[c] = 1'b0;
      chan_atten[c] = VOL_SILENT;
    end
    lfsr = LFSR_TOP;
    phase_acc = '0;
  endtask

  // Noise shift rate: fixed 32/64/128 ticks, or twice the third tone's period.
  function automatic logic [PERIOD_W-1:0] noise_step_period();
    if (reg_val[REG_NOISE][1:0] == NOISE_RATE_TONE2)
      return {chan_period[2][PERIOD_W-2:0], 1'b0};
    return PERIOD_W'(32) << reg_val[REG_NOISE][1:0];
  endfunction

  task automatic psg_write(input logic [7:0] b);
    logic [2:0] r;
    logic is_latch;
    is_latch = b[7];
    if (is_latch) begin
      r = b[6:4];
      sel_reg = r;
      reg_val[r] = {reg_val[r][TONE_W-1:4], b[3:0]};
    end else begin
      r = sel_reg;
    end
    if (r == REG_TONE0 || r == REG_TONE1 || r == REG_TONE2) begin
      if (!is_latch) reg_val[r] = {b[5:0], reg_val[r][3:0]};
      // a tone value of zero means the longest period
      chan_period[r[2:1]] = (reg_val[r] != '0) ? {2'b00, reg_val[r]} : PERIOD_RST;
      if (r == REG_TONE2 && reg_val[REG_NOISE][1:0] == NOISE_RATE_TONE2)
        chan_period[3] = noise_step_period();
    end else if (r == REG_NOISE) begin
      if (!is_latch) reg_val[r] = {reg_val[r][TONE_W-1:4], b[3:0]};
      chan_period[3] = noise_step_period();
      lfsr = LFSR_TOP;
    end else begin
      chan_atten[r[2:1]] = b[3:0];
      if (!is_latch) reg_val[r] = {reg_val[r][TONE_W-1:4], b[3:0]};
    end
  endtask

  task automatic psg_chip_tick();
    int c;
    logic fb;
    for (c = 0; c < 3; c++) begin
      if (chan_count[c] <= 1) begin
        chan_level[c] = ~chan_level[c];
        chan_count[c] = chan_period[c];
      end else begin
        chan_count[c] = chan_count[c] - 1'b1;
      end
    end
    if (chan_count[3] <= 1) begin
      // white noise feeds back both taps, periodic noise only the low one
      fb = lfsr[2] ^ (lfsr[3] & reg_val[REG_NOISE][2]);
      lfsr = {fb, lfsr[LFSR_W-1:1]};
      chan_level[3] = lfsr[0];
      chan_count[3] = chan_period[3];
    end else begin
      chan_count[3] = chan_count[3] - 1'b1;
    end
  endtask

  task automatic run_psg_item(input cmd_kind_t kind, input logic [7:0] b);
    logic [ACC_W-1:0] modulus;
    int unsigned mix;
    int c;
    if (kind == CMD_WRITE) begin
      psg_write(b);
      return;
    end
    // a sample rate of zero divides as one
    modulus = (cfg_srate != '0) ? ACC_W'(cfg_srate) : ACC_W'(1);
    phase_acc = phase_acc + ACC_W'(cfg_tick);
    while (phase_acc >= modulus) begin
      phase_acc = phase_acc - modulus;
      psg_chip_tick();
    end
    mix = 0;
    for (c = 0; c < NCHAN; c++)
      if (chan_level[c]) mix += atten_level[chan_atten[c]];
    sample_expect_q.push_back(SAMPLE_W'((mix * cfg_gain) >> 8));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_write(input logic [7:0] b);
    cmd_backlog.push_back('{CMD_WRITE, b});
  endtask

  // data byte of a sample item is don't-care; keep it random
  task automatic queue_sample();
    cmd_backlog.push_back('{CMD_SAMPLE, 8'($urandom)});
  endtask

  task automatic flag_sample_error(input string what, input logic [SAMPLE_W-1:0] want,
                                   input logic [OUT_TDATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected sample_value %0d, got m_tdata 0x%06h",
               $time, what, want, got);
  endtask

  // Write one register; the predictor is updated as the write is driven, since no item is in flight.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TICK_RATE:  cfg_tick = val[TICK_W-1:0];
      CFG_AUDIO_RATE: cfg_srate = val[SRATE_W-1:0];
      CFG_GAIN:       cfg_gain = val[GAIN_W-1:0];
      default: ;  // unknown index: no effect
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Poll at the falling edge so the driver and monitor have finished the rising one.
  task automatic drain_and_settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || s_tvalid || sample_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register setting followed by a random mix of latch bytes, data bytes, random bytes
  // and sample items.
  task automatic run_phase(input logic [CFG_W-1:0] tick_word, input logic [CFG_W-1:0] srate_word,
                           input logic [CFG_W-1:0] gain_word, input int count, input bit calm);
    int unsigned pick;
    no_idle = calm;
    write_cfg(CFG_TICK_RATE, tick_word);
    write_cfg(CFG_AUDIO_RATE, srate_word);
    write_cfg(CFG_GAIN, gain_word);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) queue_sample();
      else if (pick < 70) queue_write({1'b1, 7'($urandom)});
      // data bytes mostly keep tone periods short so the channels toggle
      else if (pick < 85) queue_write(($urandom_range(0, 2) == 0) ?
                                      8'($urandom_range(0, 127)) : 8'($urandom_range(0, 1)));
      else queue_write(8'($urandom));
    end
    drain_and_settle();
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer items from the backlog with random gaps; predict on accept.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    psg_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        run_psg_item(cmd_kind_t'(s_tuser), s_tdata);
        items_accepted++;
        if (items_accepted == DRAIN_AT_ITEM) drain_pause = 1'b1;
      end
      if (!s_tvalid || s_tready) begin
        if (drain_pause && sample_expect_q.size() != 0) begin
          // hold off until every pending sample is out
          s_tvalid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          drain_pause = 1'b0;
          nxt = cmd_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data_byte;
          s_tuser <= nxt.kind;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted sample against the oldest prediction and
  // throttle m_tready, including one long hold to back up the input side.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        samples_seen++;
        if (sample_expect_q.size() == 0) begin
          flag_sample_error("sample with none pending", '0, m_tdata);
        end else begin
          want = sample_expect_q.pop_front();
          if (m_tdata !== OUT_TDATA_W'(want))
            flag_sample_error("sample mismatch", want, m_tdata);
        end
        if (samples_seen == HOLD_AT_SAMPLE) long_hold = LONG_HOLD_CYCLES;
      end
      if (long_hold > 0) begin
        long_hold--;
        m_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int unsigned srate;
    int unsigned tick_cap;
    psg_reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at the power-on rates.
    queue_sample();          // everything silent
    queue_write(8'hFF);      // latch noise volume, silent
    queue_write(8'h00);      // data byte to noise volume: loudest
    queue_write(8'h81);      // tone 0 low nibble 1
    queue_write(8'h00);      // tone 0 high bits zero: period 1
    queue_write(8'h90);      // tone 0 loudest
    queue_sample();
    queue_write(8'hA2);      // tone 1 low nibble 2
    queue_write(8'h40);      // bit 6 of a data byte is dropped: period 2
    queue_write(8'hB5);      // latch tone 1 volume
    queue_write(8'h0E);      // volume by data byte
    queue_write(8'hC0);      // tone 2 zero value: longest period
    queue_write(8'h00);
    queue_write(8'hD3);      // tone 2 volume
    queue_sample();
    queue_write(8'hE7);      // white noise at the tone 2 rate, reload shifter
    queue_sample();
    queue_write(8'hC3);      // new tone 2 period: noise rate follows it
    queue_write(8'h00);
    queue_sample();
    queue_write(8'hE0);      // latch noise control
    queue_write(8'h03);      // data byte to noise: periodic, tone 2 rate
    queue_sample();
    queue_sample();
    drain_and_settle();

    // Sample rate of one, then zero rates with zero gain, then all registers at max.
    run_phase(20'd3, {2'($urandom), 18'd1}, {8'($urandom), 12'($urandom_range(1, 4095))},
              150, 1'b0);
    run_phase(20'd0, {2'($urandom), 18'd0}, {8'($urandom), 12'd0}, 50, 1'b1);
    write_cfg(CFG_UNKNOWN_IDX, 20'($urandom));
    run_phase(20'hFFFFF, {2'($urandom), 18'h3FFFF}, {8'($urandom), 12'hFFF}, 150, 1'b0);

    // Random settings; keep ticks per sample bounded so the run stays short.
    for (p = 0; p < 6; p++) begin
      srate = $urandom_range(64, 262143);
      tick_cap = (srate * 40 > 1048575) ? 1048575 : srate * 40;
      run_phase(20'($urandom_range(0, tick_cap)), {2'($urandom), 18'(srate)},
                {8'($urandom), 12'($urandom)}, 150, (p == 2));
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sample_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/psg_pkg.sv
hw/rtl/psg_front.sv
hw/rtl/psg_queue.sv
hw/rtl/psg_back.sv
hw/rtl/square_noise_sound_generator.sv
dv/square_noise_sound_generator_test.sv
